// ===== design/bsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bsd_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [7:0] BSLASH    = 8'h5C;
    localparam logic [7:0] ESC_BYTE  = 8'h1B;
    localparam logic [10:0] DEC_HUNDRED = 11'd100;
    localparam logic [10:0] DEC_TEN     = 11'd10;

    typedef enum logic [1:0] {
        ESC_HEX2 = 2'd0,
        ESC_DEC3 = 2'd1,
        ESC_HEX4 = 2'd2,
        ESC_HEX8 = 2'd3
    } esc_kind_t;

    typedef enum logic [1:0] {
        JOB_BYTE = 2'd0,
        JOB_PAIR = 2'd1,
        JOB_ESC  = 2'd2,
        JOB_TAIL = 2'd3
    } job_kind_t;

    typedef logic [7:0][7:0] byte_vec_t;

    typedef struct packed {
        job_kind_t kind;
        esc_kind_t esc;
        logic [2:0] len;
        logic       last;
        byte_vec_t  data;
    } job_t;

    typedef struct packed {
        logic       bad;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic      valid;
        esc_kind_t kind;
    } letter_t;

    typedef struct packed {
        logic       known;
        logic [7:0] code;
    } simple_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            bad;
    } esc_result_t;

    function automatic hex_t hex_val(input logic [7:0] c);
        hex_t r;
        logic [7:0] d;
        r = '0;
        d = '0;
        if (c >= "0" && c <= "9")
        begin
            d = c - "0";
            r.val = d[3:0];
        end
        else if (c >= "a" && c <= "f")
        begin
            d = c - "a" + 8'd10;
            r.val = d[3:0];
        end
        else if (c >= "A" && c <= "F")
        begin
            d = c - "A" + 8'd10;
            r.val = d[3:0];
        end
        else
        begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    function automatic letter_t kind_of(input logic [7:0] c);
        letter_t r;
        r.valid = 1'b1;
        r.kind  = ESC_HEX2;
        unique case (c)
            "x":     r.kind = ESC_HEX2;
            "0":     r.kind = ESC_DEC3;
            "u":     r.kind = ESC_HEX4;
            "U":     r.kind = ESC_HEX8;
            default: r.valid = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] need_digits(input esc_kind_t k);
        logic [3:0] n;
        unique case (k)
            ESC_HEX2: n = 4'd2;
            ESC_DEC3: n = 4'd3;
            ESC_HEX4: n = 4'd4;
            ESC_HEX8: n = 4'd8;
        endcase
        return n;
    endfunction

    function automatic simple_t simple_map(input logic [7:0] c);
        simple_t r;
        r.known = 1'b1;
        r.code  = c;
        unique case (c)
            "n":      r.code = 8'h0A;
            "r":      r.code = 8'h0D;
            BSLASH:   r.code = BSLASH;
            "a":      r.code = 8'h07;
            "b":      r.code = 8'h08;
            "e", "E": r.code = ESC_BYTE;
            "f":      r.code = 8'h0C;
            "t":      r.code = 8'h09;
            "v":      r.code = 8'h0B;
            default:  r.known = 1'b0;
        endcase
        return r;
    endfunction

    // Completes a digit escape from the digits in the low bytes of d.
    function automatic esc_result_t decode_escape(input esc_kind_t k, input byte_vec_t d);
        esc_result_t r;
        hex_t        h [8];
        logic [10:0] sum;
        logic [2:0]  pairs;
        r = '0;
        sum = '0;
        pairs = 3'd1;
        for (int i = 0; i < 8; i++)
        begin
            h[i] = hex_val(d[i]);
        end
        if (k == ESC_DEC3)
        begin
            sum = 11'(h[0].val) * DEC_HUNDRED + 11'(h[1].val) * DEC_TEN + 11'(h[2].val);
            r.bytes[0] = sum[7:0];
            r.count = 3'd1;
            r.bad = h[0].bad | h[1].bad | h[2].bad;
        end
        else
        begin
            pairs = (k == ESC_HEX2) ? 3'd1 : (k == ESC_HEX4) ? 3'd2 : 3'd4;
            for (int i = 0; i < 4; i++)
            begin
                r.bytes[i] = {h[2 * i].val, h[2 * i + 1].val};
                if (3'(i) < pairs)
                begin
                    r.bad = r.bad | h[2 * i].bad | h[2 * i + 1].bad;
                end
            end
            r.count = pairs;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/backslash_escape_decoder.sv =====
// Decodes a C-style backslash-escaped byte string into raw bytes.
// The input stream carries one raw byte per item, with tlast on the last byte of
// the string. The output stream carries one decoded byte per item, with tlast on
// the last byte when the final input byte yields output, and tuser on an error item.
// A digit escape with a character that is not a hex digit yields one error item
// (data zero, tlast and tuser high); the rest of that string is dropped.
// Plain text and simple escapes run at one item per cycle on both sides while the
// receiver is ready; each accepted item is registered in the queue, then in the
// output buffer. A completed digit escape yields its one to four bytes on
// consecutive cycles while the receiver is ready. A string that ends inside a
// digit escape is first re-parsed by the tail walker, one token per cycle.
// A queue of QUEUE_DEPTH entries sits between the input parser and the output
// side, so the input keeps flowing while results wait to be taken.
// When the receiver stalls, the current result holds and tready drops once the
// queue is full. Reset returns the parser to plain text and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module backslash_escape_decoder #(
    parameter int unsigned QUEUE_DEPTH = bsd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] char_out
    output logic            m_axis_tlast,
    output logic            m_axis_tuser    // [0] bad_digit
);
    import bsd_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    job_t push_job;
    job_t head_job;

    bsd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (push_job)
    );

    bsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_job)
    );

    bsd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_job         (head_job),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // An error item always closes its string.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("error item without tlast");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("job popped from an empty queue");

endmodule

`default_nettype wire

// ===== design/bsd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    input  wire logic [7:0]    s_axis_tdata,
    input  wire logic          s_axis_tlast,
    output logic               s_axis_tready,
    input  wire logic          q_full,
    output logic               q_push,
    output bsd_pkg::job_t      q_job
);
    import bsd_pkg::*;

    typedef enum logic [1:0] {
        PH_PLAIN,
        PH_BSLASH,
        PH_DIGITS
    } phase_t;

    phase_t     phase_reg, phase_next;
    esc_kind_t  esc_reg, esc_next;
    logic [2:0] held_reg, held_next;
    logic       digit_bad_reg, digit_bad_next;
    logic       skip_reg, skip_next;
    byte_vec_t  store_reg, store_next;

    logic       accept;
    logic [3:0] held_inc;
    hex_t       hc;
    letter_t    kc;
    simple_t    sm;

    assign s_axis_tready = !q_full;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign held_inc = {1'b0, held_reg} + 4'd1;
    assign hc = hex_val(s_axis_tdata);
    assign kc = kind_of(s_axis_tdata);
    assign sm = simple_map(s_axis_tdata);

    always_comb
    begin
        store_next = store_reg;
        if (accept && !skip_reg && phase_reg == PH_DIGITS)
        begin
            store_next[held_reg] = s_axis_tdata;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        esc_next       = esc_reg;
        held_next      = held_reg;
        digit_bad_next = digit_bad_reg;
        skip_next      = skip_reg;
        q_push         = 1'b0;
        q_job.kind     = JOB_BYTE;
        q_job.esc      = esc_reg;
        q_job.len      = held_inc[2:0];
        q_job.last     = s_axis_tlast;
        q_job.data     = '0;
        q_job.data[0]  = s_axis_tdata;

        if (accept)
        begin
            if (skip_reg)
            begin
                // Input after a bad digit is dropped up to the end of the string.
                if (s_axis_tlast)
                begin
                    skip_next = 1'b0;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_PLAIN:
                    begin
                        if (s_axis_tdata == BSLASH && !s_axis_tlast)
                        begin
                            phase_next = PH_BSLASH;
                        end
                        else
                        begin
                            q_push = 1'b1;
                        end
                    end
                    PH_BSLASH:
                    begin
                        phase_next = PH_PLAIN;
                        if (kc.valid)
                        begin
                            if (!s_axis_tlast)
                            begin
                                phase_next     = PH_DIGITS;
                                esc_next       = kc.kind;
                                held_next      = 3'd0;
                                digit_bad_next = 1'b0;
                            end
                        end
                        else if (sm.known)
                        begin
                            q_push        = 1'b1;
                            q_job.data[0] = sm.code;
                        end
                        else
                        begin
                            q_push     = 1'b1;
                            q_job.kind = JOB_PAIR;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (held_inc >= need_digits(esc_reg))
                        begin
                            q_push     = 1'b1;
                            q_job.kind = JOB_ESC;
                            q_job.data = store_next;
                            phase_next = PH_PLAIN;
                            held_next  = 3'd0;
                            if ((digit_bad_reg || hc.bad) && !s_axis_tlast)
                            begin
                                skip_next = 1'b1;
                            end
                        end
                        else if (s_axis_tlast)
                        begin
                            // The string ends inside the escape: the held digits are
                            // decoded again as ordinary text.
                            q_push     = 1'b1;
                            q_job.kind = JOB_TAIL;
                            q_job.data = store_next;
                        end
                        else
                        begin
                            held_next      = held_inc[2:0];
                            digit_bad_next = digit_bad_reg | hc.bad;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_PLAIN;
                    end
                endcase

                if (s_axis_tlast)
                begin
                    phase_next = PH_PLAIN;
                    held_next  = 3'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PLAIN;
            esc_reg       <= ESC_HEX2;
            held_reg      <= 3'd0;
            digit_bad_reg <= 1'b0;
            skip_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            esc_reg       <= esc_next;
            held_reg      <= held_next;
            digit_bad_reg <= digit_bad_next;
            skip_reg      <= skip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

endmodule

`default_nettype wire

// ===== design/bsd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsd_queue #(
    parameter int unsigned DEPTH = bsd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire bsd_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               valid,
    output bsd_pkg::job_t      head
);
    import bsd_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    job_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== design/bsd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire bsd_pkg::job_t q_job,
    output logic               q_pop,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [7:0]         m_axis_tdata,
    output logic               m_axis_tlast,
    output logic               m_axis_tuser
);
    import bsd_pkg::*;

    // Tail walker: re-parses held digits as text, one token per cycle.
    logic       walk_reg, walk_next;
    byte_vec_t  tbuf_reg, tbuf_next;
    logic [2:0] trem_reg, trem_next;
    byte_vec_t  wbuf_reg, wbuf_next;
    logic [3:0] wcnt_reg, wcnt_next;
    logic       wbad_reg, wbad_next;

    // Output buffer: drained from the low byte, one item per cycle while the receiver is ready.
    byte_vec_t  obuf_reg, obuf_next;
    logic [3:0] ocnt_reg, ocnt_next;
    logic       ofin_reg, ofin_next;
    logic       obad_reg, obad_next;

    logic        out_take;
    logic        load_ok;
    esc_result_t dec_job;

    logic [7:0]  b0, b1;
    letter_t     wk;
    simple_t     wsm;
    logic [3:0]  wnd;
    logic [3:0]  wnd_take;
    esc_result_t wdec;
    logic [2:0]  step_cnt;
    logic [2:0]  step_take;
    logic [7:0]  step_o0, step_o1;
    logic        step_bad;

    assign out_take = (ocnt_reg != 4'd0) && m_axis_tready;
    assign load_ok  = (ocnt_reg == 4'd0) || (ocnt_reg == 4'd1 && m_axis_tready);
    assign q_pop    = !walk_reg && q_valid && (q_job.kind == JOB_TAIL || load_ok);
    assign dec_job  = decode_escape(q_job.esc, q_job.data);

    assign b0       = tbuf_reg[0];
    assign b1       = tbuf_reg[1];
    assign wk       = kind_of(b1);
    assign wsm      = simple_map(b1);
    assign wnd      = need_digits(wk.kind);
    assign wnd_take = wnd + 4'd2;
    assign wdec     = decode_escape(wk.kind, byte_vec_t'(tbuf_reg >> 16));

    always_comb
    begin
        step_cnt  = 3'd1;
        step_take = 3'd1;
        step_o0   = b0;
        step_o1   = b1;
        step_bad  = 1'b0;
        if (b0 != BSLASH || trem_reg == 3'd1)
        begin
            step_cnt  = 3'd1;
            step_take = 3'd1;
        end
        else if (wk.valid)
        begin
            if ({1'b0, trem_reg} > wnd + 4'd1)
            begin
                step_cnt  = wdec.count;
                step_take = wnd_take[2:0];
                step_o0   = wdec.bytes[0];
                step_o1   = wdec.bytes[1];
                step_bad  = wdec.bad;
            end
            else
            begin
                // Nested escape cut short: backslash and letter dropped, digits follow as text.
                step_cnt  = 3'd0;
                step_take = 3'd2;
            end
        end
        else if (wsm.known)
        begin
            step_cnt  = 3'd1;
            step_take = 3'd2;
            step_o0   = wsm.code;
        end
        else
        begin
            step_cnt  = 3'd2;
            step_take = 3'd2;
            step_o0   = BSLASH;
            step_o1   = b1;
        end
    end

    always_comb
    begin
        walk_next = walk_reg;
        tbuf_next = tbuf_reg;
        trem_next = trem_reg;
        wbuf_next = wbuf_reg;
        wcnt_next = wcnt_reg;
        wbad_next = wbad_reg;
        obuf_next = obuf_reg;
        ocnt_next = ocnt_reg;
        ofin_next = ofin_reg;
        obad_next = obad_reg;

        if (out_take)
        begin
            obuf_next = obuf_reg >> 8;
            ocnt_next = ocnt_reg - 4'd1;
        end

        if (walk_reg)
        begin
            if (trem_reg != 3'd0)
            begin
                if (step_cnt >= 3'd1)
                begin
                    wbuf_next[wcnt_reg[2:0]] = step_o0;
                end
                if (step_cnt >= 3'd2)
                begin
                    wbuf_next[wcnt_reg[2:0] + 3'd1] = step_o1;
                end
                wcnt_next = wcnt_reg + 4'(step_cnt);
                wbad_next = wbad_reg | step_bad;
                trem_next = trem_reg - step_take;
                tbuf_next = tbuf_reg >> {step_take, 3'b000};
            end
            else if (load_ok)
            begin
                walk_next = 1'b0;
                ofin_next = 1'b1;
                if (wbad_reg)
                begin
                    obuf_next = '0;
                    ocnt_next = 4'd1;
                    obad_next = 1'b1;
                end
                else
                begin
                    obuf_next = wbuf_reg;
                    ocnt_next = wcnt_reg;
                    obad_next = 1'b0;
                end
            end
        end
        else if (q_pop)
        begin
            unique case (q_job.kind)
                JOB_BYTE:
                begin
                    obuf_next    = '0;
                    obuf_next[0] = q_job.data[0];
                    ocnt_next    = 4'd1;
                    ofin_next    = q_job.last;
                    obad_next    = 1'b0;
                end
                JOB_PAIR:
                begin
                    obuf_next    = '0;
                    obuf_next[0] = BSLASH;
                    obuf_next[1] = q_job.data[0];
                    ocnt_next    = 4'd2;
                    ofin_next    = q_job.last;
                    obad_next    = 1'b0;
                end
                JOB_ESC:
                begin
                    obuf_next = '0;
                    if (dec_job.bad)
                    begin
                        ocnt_next = 4'd1;
                        ofin_next = 1'b1;
                        obad_next = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            obuf_next[i] = dec_job.bytes[i];
                        end
                        ocnt_next = {1'b0, dec_job.count};
                        ofin_next = q_job.last;
                        obad_next = 1'b0;
                    end
                end
                JOB_TAIL:
                begin
                    walk_next = 1'b1;
                    tbuf_next = q_job.data;
                    trem_next = q_job.len;
                    wcnt_next = 4'd0;
                    wbad_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg <= 1'b0;
            trem_reg <= 3'd0;
            wcnt_reg <= 4'd0;
            wbad_reg <= 1'b0;
            ocnt_reg <= 4'd0;
            ofin_reg <= 1'b0;
            obad_reg <= 1'b0;
        end
        else
        begin
            walk_reg <= walk_next;
            trem_reg <= trem_next;
            wcnt_reg <= wcnt_next;
            wbad_reg <= wbad_next;
            ocnt_reg <= ocnt_next;
            ofin_reg <= ofin_next;
            obad_reg <= obad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tbuf_reg <= tbuf_next;
        wbuf_reg <= wbuf_next;
        obuf_reg <= obuf_next;
    end

    assign m_axis_tvalid = (ocnt_reg != 4'd0);
    assign m_axis_tdata  = obuf_reg[0];
    assign m_axis_tlast  = ofin_reg && (ocnt_reg == 4'd1);
    assign m_axis_tuser  = obad_reg;

endmodule

`default_nettype wire

// ===== tb/escape_decode_checker.sv =====
`timescale 1ns / 1ps

module escape_decode_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    input  wire logic       s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,
    input  wire logic       s_axis_tlast,
    input  wire logic       m_axis_tvalid,
    input  wire logic       m_axis_tready,
    input  wire logic [7:0] m_axis_tdata,
    input  wire logic       m_axis_tlast,
    input  wire logic       m_axis_tuser,
    output int unsigned     failures,
    output int unsigned     outstanding
);

    typedef enum logic [1:0] {
        SCAN_TEXT,
        SCAN_SLASH,
        SCAN_DIGITS
    } scan_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } decoded_t;

    scan_phase_t         scan_phase = SCAN_TEXT;
    bsd_pkg::esc_kind_t  pending_kind = bsd_pkg::ESC_HEX2;
    logic [3:0]          digit_count = '0;
    logic [7:0][7:0]     digit_bytes = '0;
    logic                dropping = 1'b0;

    logic [7:0]          step_bytes[$];
    logic                step_bad;
    decoded_t            decoded_q[$];

    initial
    begin
        failures = 0;
        outstanding = 0;
    end

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= "0" && c <= "9")
            v = c - "0";
        else if (c >= "a" && c <= "f")
            v = c - "a" + 8'd10;
        else if (c >= "A" && c <= "F")
            v = c - "A" + 8'd10;
        else
            step_bad = 1'b1;
        return v[3:0];
    endfunction

    function automatic logic digit_letter(input logic [7:0] c, output bsd_pkg::esc_kind_t k);
        logic hit;
        hit = 1'b1;
        k = bsd_pkg::ESC_HEX2;
        case (c)
            "x":     k = bsd_pkg::ESC_HEX2;
            "0":     k = bsd_pkg::ESC_DEC3;
            "u":     k = bsd_pkg::ESC_HEX4;
            "U":     k = bsd_pkg::ESC_HEX8;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic int digits_needed(input bsd_pkg::esc_kind_t k);
        case (k)
            bsd_pkg::ESC_HEX2: return 2;
            bsd_pkg::ESC_DEC3: return 3;
            bsd_pkg::ESC_HEX4: return 4;
            default:           return 8;
        endcase
    endfunction

    task automatic push_simple(input logic [7:0] c);
        case (c)
            "n":            step_bytes.push_back(8'h0A);
            "r":            step_bytes.push_back(8'h0D);
            bsd_pkg::BSLASH: step_bytes.push_back(bsd_pkg::BSLASH);
            "a":            step_bytes.push_back(8'h07);
            "b":            step_bytes.push_back(8'h08);
            "e", "E":       step_bytes.push_back(bsd_pkg::ESC_BYTE);
            "f":            step_bytes.push_back(8'h0C);
            "t":            step_bytes.push_back(8'h09);
            "v":            step_bytes.push_back(8'h0B);
            default:
            begin
                step_bytes.push_back(bsd_pkg::BSLASH);
                step_bytes.push_back(c);
            end
        endcase
    endtask

    task automatic finish_escape(input bsd_pkg::esc_kind_t k, input logic [7:0][7:0] d);
        logic [10:0] sum;
        int          pairs;
        if (k == bsd_pkg::ESC_DEC3)
        begin
            sum = 11'(digit_value(d[0])) * 11'd100 + 11'(digit_value(d[1])) * 11'd10
                + 11'(digit_value(d[2]));
            step_bytes.push_back(sum[7:0]);
        end
        else
        begin
            pairs = (k == bsd_pkg::ESC_HEX2) ? 1 : (k == bsd_pkg::ESC_HEX4) ? 2 : 4;
            for (int p = 0; p < pairs; p++)
                step_bytes.push_back({digit_value(d[2 * p]), digit_value(d[2 * p + 1])});
        end
    endtask

    // The held digits are walked again as plain escaped text that ends the string.
    task automatic decode_tail(input logic [7:0][7:0] s, input int n);
        int                 i;
        int                 nd;
        bsd_pkg::esc_kind_t k;
        i = 0;
        while (i < n && step_bytes.size() <= 6)
        begin
            if (s[i] != bsd_pkg::BSLASH)
                step_bytes.push_back(s[i]);
            else if (i + 1 < n)
            begin
                i++;
                if (digit_letter(s[i], k))
                begin
                    nd = digits_needed(k);
                    if (i + nd < n)
                    begin
                        finish_escape(k, s >> (8 * (i + 1)));
                        i += nd;
                    end
                end
                else
                    push_simple(s[i]);
            end
            else
                step_bytes.push_back(s[i]);
            i++;
        end
    endtask

    task automatic predict_item(input logic [7:0] c, input logic fin);
        bsd_pkg::esc_kind_t k;
        decoded_t           d;
        step_bytes.delete();
        step_bad = 1'b0;
        if (dropping)
        begin
            if (fin)
                dropping = 1'b0;
        end
        else
        begin
            case (scan_phase)
                SCAN_SLASH:
                begin
                    if (digit_letter(c, k))
                    begin
                        if (!fin)
                        begin
                            scan_phase = SCAN_DIGITS;
                            pending_kind = k;
                            digit_count = '0;
                        end
                    end
                    else
                    begin
                        push_simple(c);
                        scan_phase = SCAN_TEXT;
                    end
                end
                SCAN_DIGITS:
                begin
                    digit_bytes[digit_count[2:0]] = c;
                    digit_count = digit_count + 4'd1;
                    if (int'(digit_count) >= digits_needed(pending_kind))
                    begin
                        finish_escape(pending_kind, digit_bytes);
                        scan_phase = SCAN_TEXT;
                        digit_count = '0;
                    end
                    else if (fin)
                        decode_tail(digit_bytes, int'(digit_count));
                end
                default:
                begin
                    if (c == bsd_pkg::BSLASH && !fin)
                        scan_phase = SCAN_SLASH;
                    else
                        step_bytes.push_back(c);
                end
            endcase
            if (fin || step_bad)
            begin
                scan_phase = SCAN_TEXT;
                digit_count = '0;
            end
            if (step_bad)
            begin
                if (!fin)
                    dropping = 1'b1;
                d = '{data: 8'h00, last: 1'b1, bad: 1'b1};
                decoded_q.push_back(d);
            end
            else
            begin
                for (int j = 0; j < step_bytes.size(); j++)
                begin
                    d = '{data: step_bytes[j], last: fin && (j == step_bytes.size() - 1),
                          bad: 1'b0};
                    decoded_q.push_back(d);
                end
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        failures++;
    endtask

    task automatic check_result();
        decoded_t want;
        if (decoded_q.size() == 0)
            report_mismatch($sformatf("unexpected item data %02h last %0b user %0b",
                                      m_axis_tdata, m_axis_tlast, m_axis_tuser));
        else
        begin
            want = decoded_q.pop_front();
            if (m_axis_tdata !== want.data)
                report_mismatch($sformatf("data %02h, expected %02h", m_axis_tdata, want.data));
            if (m_axis_tlast !== want.last)
                report_mismatch($sformatf("last %0b, expected %0b", m_axis_tlast, want.last));
            if (m_axis_tuser !== want.bad)
                report_mismatch($sformatf("user %0b, expected %0b", m_axis_tuser, want.bad));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_phase = SCAN_TEXT;
            pending_kind = bsd_pkg::ESC_HEX2;
            digit_count = '0;
            dropping = 1'b0;
            decoded_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                predict_item(s_axis_tdata, s_axis_tlast);
        end
        outstanding = decoded_q.size();
    end

endmodule

// ===== tb/tb_backslash_escape_decoder.sv =====
`timescale 1ns / 1ps

module tb_backslash_escape_decoder;

    localparam int TOTAL_ITEMS  = 330;
    localparam int QUIET_ITEMS  = 50;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 24;
    localparam int STALL_LIMIT  = 2000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tready = 1'b0;
    wire logic       s_axis_tready;
    wire logic       m_axis_tvalid;
    wire logic [7:0] m_axis_tdata;
    wire logic       m_axis_tlast;
    wire logic       m_axis_tuser;

    int unsigned failures;
    int unsigned outstanding;

    logic [7:0] text_q[$];
    int         sent = 0;
    logic       quiet = 1'b0;
    logic       hold_req = 1'b0;
    logic       hold_done = 1'b0;
    int         hold_count;
    int         idle_run;

    backslash_escape_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    escape_decode_checker decode_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_item(input logic [7:0] c, input logic fin);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_item(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic send_string(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
        send_text();
    endtask

    // The long hold lets the sender keep offering until the block fills and stalls its input.
    always
    begin
        @(posedge clk);
        if (hold_req && !hold_done)
        begin
            m_axis_tready <= 1'b0;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                @(posedge clk);
            hold_done = 1'b1;
            m_axis_tready <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 6) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
            m_axis_tready <= 1'b1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    initial
    begin
        idle_run = 0;
        while (idle_run < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        string      simple_letters;
        string      named_letters;
        string      hex_chars;
        string      digit_letters;
        string      tail_chars;
        int         tokens;
        int         pick;
        int         need;
        int         cut;
        logic       closed;
        logic       named;
        logic [7:0] c;
        logic [7:0] letter;
        simple_letters = "nr\\abeEftv";
        named_letters = "nr\\abeEftvx0uU";
        hex_chars = "0123456789abcdefABCDEF";
        digit_letters = "x0uU";
        tail_chars = "\\xu0Un7aZ";

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        text_q = '{8'h00, 8'hFF};
        send_text();
        send_string("\\n\\r\\\\\\a\\b\\e\\E\\f\\t\\v\\q");
        send_string("\\x4a\\0255\\0FfF\\u00e9\\UdEaDBEEF");
        send_string("\\x7g!z");
        send_string("A");
        send_string("\\u12");
        send_string("\\x");
        send_string("\\");
        send_string("\\U\\n1");
        send_string("\\U\\x4");
        send_string("\\x1z");

        hold_req = 1'b1;
        while (sent < TOTAL_ITEMS)
        begin
            text_q.delete();
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 10))
                begin
                    c = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 2) == 0)
                        c = bsd_pkg::BSLASH;
                    text_q.push_back(c);
                end
            end
            else
            begin
                tokens = $urandom_range(1, 8);
                closed = 1'b0;
                for (int t = 0; t < tokens && !closed; t++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 35)
                    begin
                        do
                            c = 8'($urandom_range(0, 255));
                        while (c == bsd_pkg::BSLASH);
                        text_q.push_back(c);
                    end
                    else if (pick < 55)
                    begin
                        text_q.push_back(bsd_pkg::BSLASH);
                        text_q.push_back(simple_letters[$urandom_range(0, 9)]);
                    end
                    else if (pick < 62)
                    begin
                        do
                        begin
                            c = 8'($urandom_range(0, 255));
                            named = 1'b0;
                            for (int j = 0; j < named_letters.len(); j++)
                                if (named_letters[j] == c)
                                    named = 1'b1;
                        end
                        while (named);
                        text_q.push_back(bsd_pkg::BSLASH);
                        text_q.push_back(c);
                    end
                    else if (pick < 93)
                    begin
                        letter = digit_letters[$urandom_range(0, 3)];
                        case (letter)
                            "x":     need = 2;
                            "0":     need = 3;
                            "u":     need = 4;
                            default: need = 8;
                        endcase
                        text_q.push_back(bsd_pkg::BSLASH);
                        text_q.push_back(letter);
                        repeat (need)
                        begin
                            c = hex_chars[$urandom_range(0, 21)];
                            if ($urandom_range(0, 24) == 0)
                                c = 8'($urandom_range(0, 255));
                            text_q.push_back(c);
                        end
                    end
                    else
                    begin
                        // A long escape cut short, holding text that is walked again.
                        letter = ($urandom_range(0, 1) == 0) ? "u" : "U";
                        need = (letter == "u") ? 3 : 7;
                        text_q.push_back(bsd_pkg::BSLASH);
                        text_q.push_back(letter);
                        repeat ($urandom_range(1, need))
                            text_q.push_back(tail_chars[$urandom_range(0, tail_chars.len() - 1)]);
                        closed = 1'b1;
                    end
                end
                if (!closed && $urandom_range(0, 3) == 0)
                begin
                    cut = $urandom_range(1, 3);
                    while (cut > 0 && text_q.size() > 1)
                    begin
                        void'(text_q.pop_back());
                        cut--;
                    end
                end
            end
            if (sent >= TOTAL_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            send_text();
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
